// ===== design/bpte_pkg.sv =====
// Shared types, widths, register codes and the binomial table of the Bezier evaluator.
package bpte_pkg;

  // Powers of u and 1-u are unsigned Q0.30, so 1.0 needs 31 bits.
  localparam int WFRAC = 30;
  localparam int PW_W = WFRAC + 1;

  // Highest curve degree the datapath is built for, and the slot count it implies.
  localparam int MAX_DEG = 4;
  localparam int NSLOT = MAX_DEG + 1;

  // Signed width of the basis and derivative weights (|w| < 12 * 2^30).
  localparam int WGT_W = 35;

  // Pipeline layout: power chain, weight stages, accumulate stages.
  localparam int STG_POW = 4;
  localparam int STG_WGT = 2;
  localparam int STG_ACC = 3;
  localparam int NSTG = STG_POW + STG_WGT + STG_ACC;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER  = 3'd0,
    REG_POLE_0 = 3'd1,
    REG_POLE_1 = 3'd2,
    REG_POLE_2 = 3'd3,
    REG_POLE_3 = 3'd4,
    REG_POLE_4 = 3'd5
  } cfg_reg_t;

  typedef logic [PW_W-1:0] pw_t;
  typedef pw_t [MAX_DEG:0] pw_vec_t;

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef wgt_t [MAX_DEG:0] wgt_vec_t;

  localparam logic [2:0] BINOM_TAB [NSLOT][NSLOT] = '{
    '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd2, 3'd1, 3'd0, 3'd0},
    '{3'd1, 3'd3, 3'd3, 3'd1, 3'd0},
    '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1}
  };

  // C(r,k), zero outside the triangle (negative r included).
  function automatic logic [2:0] binom(input int r, input int k);
    logic [2:0] res;
    res = '0;
    if (r >= 0 && r <= MAX_DEG && k >= 0 && k <= r) begin
      res = BINOM_TAB[r][k];
    end
    return res;
  endfunction

endpackage

// ===== design/bpte_pow.sv =====
// Power chain: clamps u and forms u^k and (1-u)^k in Q0.30 over four stages.
module bpte_pow #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic [3:0]               en_i,
  input  logic [PARAM_FRAC_BITS:0] u_i,
  output bpte_pkg::pw_vec_t        up_o,
  output bpte_pkg::pw_vec_t        vp_o
);

  localparam int F = PARAM_FRAC_BITS;
  localparam int PW_W = bpte_pkg::PW_W;
  localparam int PRW = PW_W + F + 1;
  localparam logic [F:0] U_ONE = {1'b1, {F{1'b0}}};
  localparam logic [PRW-1:0] P_HALF = {{(PRW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam bpte_pkg::pw_t W_ONE = {1'b1, {(PW_W-1){1'b0}}};

  // One power step: (p * x + 2^(F-1)) >> F.
  function automatic bpte_pkg::pw_t pstep(input bpte_pkg::pw_t p, input logic [F:0] x);
    logic [PRW-1:0] prod;
    prod = PRW'(p) * PRW'(x) + P_HALF;
    return prod[F +: PW_W];
  endfunction

  logic [F:0] u0_r, v0_r, u0_nxt;
  logic [F:0] u1_r, v1_r, u2_r, v2_r;
  bpte_pkg::pw_vec_t up1_r, vp1_r, up2_r, vp2_r, up3_r, vp3_r;
  bpte_pkg::pw_vec_t up1_nxt, vp1_nxt, up2_nxt, vp2_nxt, up3_nxt, vp3_nxt;

  assign u0_nxt = (u_i > U_ONE) ? U_ONE : u_i;

  always_comb begin
    up1_nxt = '0;
    vp1_nxt = '0;
    up1_nxt[0] = W_ONE;
    vp1_nxt[0] = W_ONE;
    up1_nxt[1] = PW_W'(u0_r) << (bpte_pkg::WFRAC - F);
    vp1_nxt[1] = PW_W'(v0_r) << (bpte_pkg::WFRAC - F);
    up1_nxt[2] = pstep(up1_nxt[1], u0_r);
    vp1_nxt[2] = pstep(vp1_nxt[1], v0_r);

    up2_nxt = up1_r;
    vp2_nxt = vp1_r;
    up2_nxt[3] = pstep(up1_r[2], u1_r);
    vp2_nxt[3] = pstep(vp1_r[2], v1_r);

    up3_nxt = up2_r;
    vp3_nxt = vp2_r;
    up3_nxt[4] = pstep(up2_r[3], u2_r);
    vp3_nxt[4] = pstep(vp2_r[3], v2_r);
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      u0_r <= u0_nxt;
      v0_r <= U_ONE - u0_nxt;
    end
    if (en_i[1]) begin
      u1_r  <= u0_r;
      v1_r  <= v0_r;
      up1_r <= up1_nxt;
      vp1_r <= vp1_nxt;
    end
    if (en_i[2]) begin
      u2_r  <= u1_r;
      v2_r  <= v1_r;
      up2_r <= up2_nxt;
      vp2_r <= vp2_nxt;
    end
    if (en_i[3]) begin
      up3_r <= up3_nxt;
      vp3_r <= vp3_nxt;
    end
  end

  assign up_o = up3_r;
  assign vp_o = vp3_r;

endmodule

// ===== design/bpte_wgt.sv =====
// Basis products u^i v^k and the Bernstein point and derivative weights, two stages.
module bpte_wgt (
  input  logic                 clk,
  input  logic [1:0]           en_i,
  input  logic [2:0]           ord_i,
  input  bpte_pkg::pw_vec_t    up_i,
  input  bpte_pkg::pw_vec_t    vp_i,
  output bpte_pkg::wgt_vec_t   b_o,
  output bpte_pkg::wgt_vec_t   d_o
);

  localparam int PW_W = bpte_pkg::PW_W;
  localparam int NSLOT = bpte_pkg::NSLOT;
  localparam int MUL_W = 2 * PW_W;
  localparam int TW = 40;
  localparam logic [MUL_W-1:0] M_HALF = MUL_W'(1) << (bpte_pkg::WFRAC - 1);

  bpte_pkg::pw_vec_t psel, qsel, p_nxt, q_nxt, p_r, q_r, qm;
  logic [NSLOT-1:0] pact, qact;
  bpte_pkg::wgt_vec_t b_nxt, d_nxt, b_r, d_r;

  // Stage one: for degree n the point needs u^i v^(n-i), the derivative u^i v^(n-1-i).
  always_comb begin
    logic [MUL_W-1:0] pm, qmul;
    psel = '0;
    qsel = '0;
    pact = '0;
    qact = '0;
    for (int m = 1; m <= NSLOT; m++) begin
      for (int i = 0; i < m; i++) begin
        if (ord_i == 3'(m)) begin
          psel[i] = vp_i[m-1-i];
          pact[i] = 1'b1;
        end
      end
      for (int i = 0; i < m - 1; i++) begin
        if (ord_i == 3'(m)) begin
          qsel[i] = vp_i[m-2-i];
          qact[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < NSLOT; i++) begin
      pm = MUL_W'(up_i[i]) * MUL_W'(psel[i]) + M_HALF;
      qmul = MUL_W'(up_i[i]) * MUL_W'(qsel[i]) + M_HALF;
      p_nxt[i] = pact[i] ? pm[bpte_pkg::WFRAC +: PW_W] : '0;
      q_nxt[i] = qact[i] ? qmul[bpte_pkg::WFRAC +: PW_W] : '0;
    end
  end

  // Stage two: b_i = C(n,i) P_i and d_i = n (C(n-1,i-1) Q_(i-1) - C(n-1,i) Q_i).
  always_comb begin
    int nn;
    logic [2:0] nmul;
    logic [TW-1:0] bf, df;
    nn = int'(ord_i) - 1;
    nmul = (ord_i == 3'd0) ? 3'd0 : ord_i - 3'd1;
    qm = '0;
    for (int i = 1; i < NSLOT; i++) begin
      qm[i] = q_r[i-1];
    end
    for (int i = 0; i < NSLOT; i++) begin
      bf = TW'(bpte_pkg::binom(nn, i)) * TW'(p_r[i]);
      df = TW'(bpte_pkg::binom(nn - 1, i - 1)) * TW'(qm[i])
         - TW'(bpte_pkg::binom(nn - 1, i)) * TW'(q_r[i]);
      df = df * TW'(nmul);
      b_nxt[i] = bf[bpte_pkg::WGT_W-1:0];
      d_nxt[i] = df[bpte_pkg::WGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      p_r <= p_nxt;
      q_r <= q_nxt;
    end
    if (en_i[1]) begin
      b_r <= b_nxt;
      d_r <= d_nxt;
    end
  end

  assign b_o = b_r;
  assign d_o = d_r;

endmodule

// ===== design/bpte_acc.sv =====
// Weighted pole sums: coordinate products, slot sums, then rounding and saturation.
module bpte_acc #(
  parameter int MAX_ORDER  = 5,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic [2:0]                   en_i,
  input  bpte_pkg::wgt_vec_t           b_i,
  input  bpte_pkg::wgt_vec_t           d_i,
  input  logic [3*COORD_BITS-1:0]      poles_i [MAX_ORDER],
  output logic signed [COORD_BITS-1:0] point_o [3],
  output logic signed [COORD_BITS+2:0] slope_o [3]
);

  localparam int WFRAC = bpte_pkg::WFRAC;
  localparam int MW = bpte_pkg::WGT_W + COORD_BITS;
  localparam int SW = MW + 3;
  localparam int RW = SW - WFRAC;
  localparam int SB = COORD_BITS + 3;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (WFRAC - 1);
  localparam logic signed [RW-1:0] P_MAX = RW'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] P_MIN = RW'(-(1 << (COORD_BITS - 1)));
  localparam logic signed [RW-1:0] S_MAX = RW'((1 << (SB - 1)) - 1);
  localparam logic signed [RW-1:0] S_MIN = RW'(-(1 << (SB - 1)));

  logic signed [MW-1:0] pp_r [MAX_ORDER][3];
  logic signed [MW-1:0] pd_r [MAX_ORDER][3];
  logic signed [MW-1:0] pp_nxt [MAX_ORDER][3];
  logic signed [MW-1:0] pd_nxt [MAX_ORDER][3];
  logic signed [SW-1:0] sp_r [3], sd_r [3], sp_nxt [3], sd_nxt [3];
  logic signed [COORD_BITS-1:0] pt_r [3], pt_nxt [3];
  logic signed [SB-1:0] sl_r [3], sl_nxt [3];

  always_comb begin
    logic signed [COORD_BITS-1:0] c;
    for (int i = 0; i < MAX_ORDER; i++) begin
      for (int a = 0; a < 3; a++) begin
        c = $signed(poles_i[i][a*COORD_BITS +: COORD_BITS]);
        pp_nxt[i][a] = MW'($signed(b_i[i])) * MW'(c);
        pd_nxt[i][a] = MW'($signed(d_i[i])) * MW'(c);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sp_nxt[a] = '0;
      sd_nxt[a] = '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        sp_nxt[a] = sp_nxt[a] + SW'(pp_r[i][a]);
        sd_nxt[a] = sd_nxt[a] + SW'(pd_r[i][a]);
      end
    end
  end

  // Round half up to Q.8 by floor((s + 2^29) / 2^30), then clip to the field range.
  always_comb begin
    logic signed [SW-1:0] tp, td;
    logic signed [RW-1:0] rp, rd;
    for (int a = 0; a < 3; a++) begin
      tp = sp_r[a] + RND;
      td = sd_r[a] + RND;
      rp = $signed(tp[SW-1:WFRAC]);
      rd = $signed(td[SW-1:WFRAC]);
      if (rp > P_MAX) begin
        pt_nxt[a] = P_MAX[COORD_BITS-1:0];
      end else if (rp < P_MIN) begin
        pt_nxt[a] = P_MIN[COORD_BITS-1:0];
      end else begin
        pt_nxt[a] = rp[COORD_BITS-1:0];
      end
      if (rd > S_MAX) begin
        sl_nxt[a] = S_MAX[SB-1:0];
      end else if (rd < S_MIN) begin
        sl_nxt[a] = S_MIN[SB-1:0];
      end else begin
        sl_nxt[a] = rd[SB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      pp_r <= pp_nxt;
      pd_r <= pd_nxt;
    end
    if (en_i[1]) begin
      sp_r <= sp_nxt;
      sd_r <= sd_nxt;
    end
    if (en_i[2]) begin
      pt_r <= pt_nxt;
      sl_r <= sl_nxt;
    end
  end

  assign point_o = pt_r;
  assign slope_o = sl_r;

endmodule

// ===== design/bezier_point_and_tangent_eval.sv =====
// Throughput: one request per cycle while the output register is not stalled.
// Each stage holds at most one multiplier level; weight stage two holds two.
// Stalls: each stage advances when it is empty or its successor advances, so
// bubbles close up and in_ready stays high while the output register is free.
// Reset: synchronous, active low; clears all valid bits, curve_order and the poles.
module bezier_point_and_tangent_eval #(
  parameter int MAX_ORDER       = 5,
  parameter int COORD_BITS      = 20,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [PARAM_FRAC_BITS:0]             in_u,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [3*COORD_BITS-1:0]              cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_BITS-1:0]         out_point_x,
  output logic signed [COORD_BITS-1:0]         out_point_y,
  output logic signed [COORD_BITS-1:0]         out_point_z,
  output logic signed [COORD_BITS+2:0]         out_slope_x,
  output logic signed [COORD_BITS+2:0]         out_slope_y,
  output logic signed [COORD_BITS+2:0]         out_slope_z
);

  localparam int NSTG = bpte_pkg::NSTG;
  localparam int P0 = 0;
  localparam int W0 = bpte_pkg::STG_POW;
  localparam int A0 = bpte_pkg::STG_POW + bpte_pkg::STG_WGT;

  // Configuration registers. Writes are always taken; codes past the last pole
  // are dropped, as are poles beyond what MAX_ORDER can ever use.
  logic [2:0] order_r;
  logic [3*COORD_BITS-1:0] poles_r [MAX_ORDER];
  logic [2:0] ord_eff;
  logic cfg_we, we_order;
  logic [bpte_pkg::NSLOT-1:0] we_pole;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  always_comb begin
    we_order = 1'b0;
    we_pole = '0;
    unique case (cfg_index)
      bpte_pkg::REG_ORDER:  we_order = cfg_we;
      bpte_pkg::REG_POLE_0: we_pole[0] = cfg_we;
      bpte_pkg::REG_POLE_1: we_pole[1] = cfg_we;
      bpte_pkg::REG_POLE_2: we_pole[2] = cfg_we;
      bpte_pkg::REG_POLE_3: we_pole[3] = cfg_we;
      bpte_pkg::REG_POLE_4: we_pole[4] = cfg_we;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        poles_r[i] <= '0;
      end
    end else begin
      if (we_order) begin
        order_r <= cfg_data[2:0];
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
        if (we_pole[i]) begin
          poles_r[i] <= cfg_data;
        end
      end
    end
  end

  // Orders above MAX_ORDER evaluate as MAX_ORDER; the weight stages read it directly.
  // Change the register only while the pipeline is empty; the block does not check.
  assign ord_eff = (order_r > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : order_r;

  // Valid bits and per-stage enables. A stage loads when it is empty or when
  // its contents move on; the last stage is the output register.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = vld_r[NSTG-1];

  // Datapath: power chain, Bernstein weights, weighted pole sums.
  bpte_pkg::pw_vec_t up, vp;
  bpte_pkg::wgt_vec_t bw, dw;
  logic signed [COORD_BITS-1:0] point [3];
  logic signed [COORD_BITS+2:0] slope [3];

  bpte_pow #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_pow (
    .clk  (clk),
    .en_i (en[W0-1:P0]),
    .u_i  (in_u),
    .up_o (up),
    .vp_o (vp)
  );

  bpte_wgt u_wgt (
    .clk   (clk),
    .en_i  (en[A0-1:W0]),
    .ord_i (ord_eff),
    .up_i  (up),
    .vp_i  (vp),
    .b_o   (bw),
    .d_o   (dw)
  );

  bpte_acc #(
    .MAX_ORDER (MAX_ORDER),
    .COORD_BITS(COORD_BITS)
  ) u_acc (
    .clk     (clk),
    .en_i    (en[NSTG-1:A0]),
    .b_i     (bw),
    .d_i     (dw),
    .poles_i (poles_r),
    .point_o (point),
    .slope_o (slope)
  );

  assign out_point_x = point[0];
  assign out_point_y = point[1];
  assign out_point_z = point[2];
  assign out_slope_x = slope[0];
  assign out_slope_y = slope[1];
  assign out_slope_z = slope[2];

endmodule

// ===== design/bpte_chk.sv =====
// Port-level checker for the Bezier evaluator, bound to the top level.
module bpte_chk #(
  parameter int COORD_BITS = 20
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [bpte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [3*COORD_BITS-1:0]              cfg_data,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [COORD_BITS-1:0]         out_point_x,
  input logic signed [COORD_BITS-1:0]         out_point_y,
  input logic signed [COORD_BITS-1:0]         out_point_z,
  input logic signed [COORD_BITS+2:0]         out_slope_x,
  input logic signed [COORD_BITS+2:0]         out_slope_y,
  input logic signed [COORD_BITS+2:0]         out_slope_z
);

  // Track whether the curve order is zero or one, as seen on the config port.
  logic ord0_r, ord1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord0_r <= 1'b1;
      ord1_r <= 1'b0;
    end else if (cfg_valid && cfg_ready && cfg_index == bpte_pkg::REG_ORDER) begin
      ord0_r <= (cfg_data[2:0] == 3'd0);
      ord1_r <= (cfg_data[2:0] == 3'd1);
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("request refused while output side is free");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x) && $stable(out_slope_x))
    else $error("stalled result dropped or changed");

  a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ord0_r |-> out_point_x == '0 && out_point_y == '0 && out_point_z == '0
      && out_slope_x == '0 && out_slope_y == '0 && out_slope_z == '0)
    else $error("order zero gave a nonzero result");

  a_order_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ord1_r |-> out_slope_x == '0 && out_slope_y == '0 && out_slope_z == '0)
    else $error("order one gave a nonzero slope");

endmodule

bind bezier_point_and_tangent_eval bpte_chk #(.COORD_BITS(COORD_BITS)) u_bpte_chk (.*);
